>>> rtl/mtrr_pkg.sv
// Shared types, codes and constants of the memory type resolver.
// Used by every module and interface of the block but mtrr_ram; it depends on nothing.
package mtrr_pkg;

    localparam int VAR_RANGES_DEF     = 8;
    localparam int PHYS_ADDR_BITS_DEF = 52;
    localparam int FIXED_COUNT        = 88;
    localparam int FIXED_AW           = $clog2(FIXED_COUNT);
    localparam int TYPE_W             = 8;
    localparam int FRAME_W            = 40;
    localparam int ADDR_W             = 52;
    localparam int SIZE_W             = 32;
    localparam int INDEX_W            = 7;
    localparam int PAGE_SHIFT         = 12;

    localparam logic [TYPE_W-1:0] TYPE_UC = 8'd0;
    localparam logic [TYPE_W-1:0] TYPE_WT = 8'd4;
    localparam logic [TYPE_W-1:0] TYPE_WB = 8'd6;

    // Fixed-range entry bases for the 16K and 4K regions.
    localparam logic [INDEX_W-1:0] FIX16K_BASE = 7'd8;
    localparam logic [INDEX_W-1:0] FIX4K_BASE  = 7'd24;

    typedef enum logic [1:0] {
        REQ_WR_FIXED = 2'd0,
        REQ_WR_VAR   = 2'd1,
        REQ_QUERY    = 2'd2,
        REQ_NONE     = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        CFG_MTRR_ENABLE  = 2'd0,
        CFG_FIXED_ON     = 2'd1,
        CFG_DEFAULT_TYPE = 2'd2,
        CFG_VAR_COUNT    = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_FIXRD,
        S_VSCAN,
        S_MERGE,
        S_CHECK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                  en;
        logic [INDEX_W-1:0]    idx;
        logic [TYPE_W-1:0]     mtype;
    } t_fix_wr;

    typedef struct packed {
        logic                  en;
        logic [INDEX_W-1:0]    idx;
        logic [FRAME_W-1:0]    base;
        logic [FRAME_W-1:0]    mask;
        logic [TYPE_W-1:0]     mtype;
        logic                  vld;
    } t_var_wr;

    // Combines two memory types: equal types stay, uncacheable wins,
    // write-through with write-back gives write-through, else uncacheable.
    function automatic logic [TYPE_W-1:0] merge_types(
        input logic [TYPE_W-1:0] a,
        input logic [TYPE_W-1:0] b
    );
        logic [TYPE_W-1:0] res;
        if (a == b) begin
            res = a;
        end else if ((a == TYPE_WT && b == TYPE_WB) || (a == TYPE_WB && b == TYPE_WT)) begin
            res = TYPE_WT;
        end else begin
            res = TYPE_UC;
        end
        return res;
    endfunction

endpackage

>>> rtl/mtrr_req_if.sv
// Request channel of the memory type resolver: valid/ready plus item fields.
// Depends on mtrr_pkg for the field widths.
interface mtrr_req_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        req_type;
    logic [mtrr_pkg::INDEX_W-1:0]      entry_index;
    logic [mtrr_pkg::FRAME_W-1:0]      base_frame;
    logic [mtrr_pkg::TYPE_W-1:0]       entry_type;
    logic [mtrr_pkg::FRAME_W-1:0]      mask_frame;
    logic                              mask_valid;
    logic [mtrr_pkg::ADDR_W-1:0]       phys_address;
    logic [mtrr_pkg::SIZE_W-1:0]       range_size;

    modport source (output valid, req_type, entry_index, base_frame, entry_type,
                    mask_frame, mask_valid, phys_address, range_size, input ready);
    modport sink   (input valid, req_type, entry_index, base_frame, entry_type,
                    mask_frame, mask_valid, phys_address, range_size, output ready);
endinterface

>>> rtl/mtrr_rsp_if.sv
// Result channel of the memory type resolver: valid/ready plus result fields.
// Depends on mtrr_pkg for the field widths.
interface mtrr_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [mtrr_pkg::TYPE_W-1:0]    mem_type;
    logic                           same_type;

    modport source (output valid, mem_type, same_type, input ready);
    modport sink   (input valid, mem_type, same_type, output ready);
endinterface

>>> rtl/mtrr_memory_type_resolver_core.sv
// Top level of the memory type resolver: sequencer, configuration registers,
// result register. Uses mtrr_pkg, mtrr_req_if, mtrr_rsp_if, mtrr_fix_tab, mtrr_var_bank.
//
// The block keeps 88 fixed-range type bytes and VAR_RANGES variable ranges and
// answers queries for the memory type of a physical byte range. A write item
// (fixed entry or variable range) is written at acceptance and gives no result.
// A query walks its start address and the start of every further 4 KiB page;
// each address passes LOOKUP, FIXRD, MERGE and CHECK when it falls in the
// fixed region (one table read) and LOOKUP, VSCAN, MERGE and CHECK otherwise;
// VSCAN tests as many ranges as the range count register, clipped to
// VAR_RANGES, because a single compare unit tests one variable range per
// cycle. With MTRRs disabled a query goes from acceptance straight to the done
// state, and once the merged type is uncacheable and the range is known not
// to be uniform the walk stops early. The request channel is ready only while
// the sequencer is idle; a finished result sits in an output register, so the
// next item can be taken while the result still waits for the sink. There is
// no clearing pass after reset.
module mtrr_memory_type_resolver_core #(
    parameter int VAR_RANGES     = mtrr_pkg::VAR_RANGES_DEF,
    parameter int PHYS_ADDR_BITS = mtrr_pkg::PHYS_ADDR_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [mtrr_pkg::TYPE_W-1:0] i_cfg_wdata,
    mtrr_req_if.sink                    i_req,
    mtrr_rsp_if.source                  o_rsp
);

    localparam int IW  = (VAR_RANGES > 1) ? $clog2(VAR_RANGES) : 1;
    localparam int CW  = $clog2(VAR_RANGES + 1);
    localparam int AW  = PHYS_ADDR_BITS + 1;   // page addresses may pass the top
    localparam int PGW = AW - mtrr_pkg::PAGE_SHIFT;

    // Configuration registers.
    logic                        r_mtrr_en;
    logic                        r_fixed_on;
    logic [mtrr_pkg::TYPE_W-1:0] r_def_type;
    logic [3:0]                  r_var_count;

    // Sequencer state.
    mtrr_pkg::t_state            r_state, n_state;
    logic [AW-1:0]               r_addr, n_addr;
    logic [AW-1:0]               r_end, n_end;
    logic [mtrr_pkg::TYPE_W-1:0] r_res, n_res;
    logic                        r_uni, n_uni;
    logic                        r_first, n_first;
    logic [CW-1:0]               r_vi, n_vi;
    logic                        r_matched, n_matched;
    logic [mtrr_pkg::TYPE_W-1:0] r_acc, n_acc;
    logic [mtrr_pkg::TYPE_W-1:0] r_t, n_t;

    // Result register.
    logic                        r_out_vld, n_out_vld;
    logic [mtrr_pkg::TYPE_W-1:0] r_out_type, n_out_type;
    logic                        r_out_uni, n_out_uni;

    logic                        req_acc;
    logic                        is_query;
    logic                        in_fixed;
    logic                        scan_done;
    logic                        out_free;
    logic [CW+3:0]               cnt_wide;
    logic [CW-1:0]               scan_cnt;
    logic [mtrr_pkg::FIXED_AW-1:0] fix_raddr;
    logic [mtrr_pkg::TYPE_W-1:0] fix_rdata;
    logic                        var_hit;
    logic [mtrr_pkg::TYPE_W-1:0] var_type;
    logic [mtrr_pkg::TYPE_W-1:0] mrg_res;
    logic                        mrg_uni;
    logic [PGW-1:0]              next_page;
    mtrr_pkg::t_fix_wr           fix_wr;
    mtrr_pkg::t_var_wr           var_wr;

    assign i_req.ready = (r_state == mtrr_pkg::S_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign is_query    = (i_req.req_type == mtrr_pkg::REQ_QUERY);
    assign out_free    = !r_out_vld || o_rsp.ready;

    // Table writes happen straight at acceptance; the tables are not read then.
    assign fix_wr.en    = req_acc && (i_req.req_type == mtrr_pkg::REQ_WR_FIXED)
                          && (i_req.entry_index < 7'(mtrr_pkg::FIXED_COUNT));
    assign fix_wr.idx   = i_req.entry_index;
    assign fix_wr.mtype = i_req.entry_type;

    assign var_wr.en    = req_acc && (i_req.req_type == mtrr_pkg::REQ_WR_VAR);
    assign var_wr.idx   = i_req.entry_index;
    assign var_wr.base  = i_req.base_frame;
    assign var_wr.mask  = i_req.mask_frame;
    assign var_wr.mtype = i_req.entry_type;
    assign var_wr.vld   = i_req.mask_valid;

    // Number of variable ranges scanned, clipped to the bank size.
    assign cnt_wide = (CW + 4)'(r_var_count);
    assign scan_cnt = (cnt_wide > (CW + 4)'(VAR_RANGES)) ? CW'(VAR_RANGES)
                                                         : cnt_wide[CW-1:0];
    assign scan_done = (r_vi == scan_cnt);

    // The fixed region is the first MiB; the three sub-regions use 64K, 16K
    // and 4K granules.
    assign in_fixed = r_fixed_on && (r_addr[AW-1:20] == '0);

    always_comb begin
        if (r_addr[19] == 1'b0) begin
            fix_raddr = mtrr_pkg::FIXED_AW'(r_addr[18:16]);
        end else if (r_addr[18] == 1'b0) begin
            fix_raddr = mtrr_pkg::FIX16K_BASE + mtrr_pkg::FIXED_AW'(r_addr[17:14]);
        end else begin
            fix_raddr = mtrr_pkg::FIX4K_BASE + mtrr_pkg::FIXED_AW'(r_addr[17:12]);
        end
    end

    mtrr_fix_tab u_fix_tab (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fix_wr),
        .i_raddr (fix_raddr),
        .o_rdata (fix_rdata)
    );

    mtrr_var_bank #(
        .VAR_RANGES     (VAR_RANGES),
        .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
    ) u_var_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (var_wr),
        .i_sel   (r_vi[IW-1:0]),
        .i_addr  (r_addr[PHYS_ADDR_BITS-1:0]),
        .o_hit   (var_hit),
        .o_type  (var_type)
    );

    // Folding the type of the current page into the running result.
    always_comb begin
        if (r_first) begin
            mrg_res = r_t;
            mrg_uni = 1'b1;
        end else begin
            mrg_res = mtrr_pkg::merge_types(r_res, r_t);
            mrg_uni = r_uni && (r_t == r_res);
        end
    end

    assign next_page = r_addr[AW-1:mtrr_pkg::PAGE_SHIFT] + PGW'(1);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mtrr_pkg::S_IDLE: begin
                if (req_acc && is_query) begin
                    n_state = r_mtrr_en ? mtrr_pkg::S_LOOKUP : mtrr_pkg::S_DONE;
                end
            end
            mtrr_pkg::S_LOOKUP: begin
                n_state = in_fixed ? mtrr_pkg::S_FIXRD : mtrr_pkg::S_VSCAN;
            end
            mtrr_pkg::S_FIXRD: begin
                n_state = mtrr_pkg::S_MERGE;
            end
            mtrr_pkg::S_VSCAN: begin
                if (scan_done) begin
                    n_state = mtrr_pkg::S_MERGE;
                end
            end
            mtrr_pkg::S_MERGE: begin
                // Nothing can change once the result is uncacheable and mixed.
                if (!mrg_uni && mrg_res == mtrr_pkg::TYPE_UC) begin
                    n_state = mtrr_pkg::S_DONE;
                end else begin
                    n_state = mtrr_pkg::S_CHECK;
                end
            end
            mtrr_pkg::S_CHECK: begin
                n_state = (r_addr < r_end) ? mtrr_pkg::S_LOOKUP : mtrr_pkg::S_DONE;
            end
            mtrr_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = mtrr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mtrr_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and result register updates.
    always_comb begin
        n_addr     = r_addr;
        n_end      = r_end;
        n_res      = r_res;
        n_uni      = r_uni;
        n_first    = r_first;
        n_vi       = r_vi;
        n_matched  = r_matched;
        n_acc      = r_acc;
        n_t        = r_t;
        n_out_vld  = r_out_vld && !o_rsp.ready;
        n_out_type = r_out_type;
        n_out_uni  = r_out_uni;
        case (r_state)
            mtrr_pkg::S_IDLE: begin
                if (req_acc && is_query) begin
                    n_addr  = {1'b0, i_req.phys_address[PHYS_ADDR_BITS-1:0]};
                    n_end   = {1'b0, i_req.phys_address[PHYS_ADDR_BITS-1:0]}
                              + AW'(i_req.range_size);
                    n_first = 1'b1;
                    // With MTRRs off every page is uncacheable.
                    n_res   = mtrr_pkg::TYPE_UC;
                    n_uni   = 1'b1;
                end
            end
            mtrr_pkg::S_LOOKUP: begin
                n_vi      = '0;
                n_matched = 1'b0;
            end
            mtrr_pkg::S_FIXRD: begin
                n_t = fix_rdata;
            end
            mtrr_pkg::S_VSCAN: begin
                if (scan_done) begin
                    n_t = r_matched ? r_acc : r_def_type;
                end else begin
                    n_vi = r_vi + CW'(1);
                    if (var_hit) begin
                        n_matched = 1'b1;
                        n_acc     = r_matched ? mtrr_pkg::merge_types(r_acc, var_type)
                                              : var_type;
                    end
                end
            end
            mtrr_pkg::S_MERGE: begin
                n_res   = mrg_res;
                n_uni   = mrg_uni;
                n_first = 1'b0;
                n_addr  = {next_page, {mtrr_pkg::PAGE_SHIFT{1'b0}}};
            end
            mtrr_pkg::S_CHECK: begin
            end
            mtrr_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_type = r_res;
                    n_out_uni  = r_uni;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mtrr_pkg::S_IDLE;
            r_out_vld   <= 1'b0;
            r_mtrr_en   <= 1'b0;
            r_fixed_on  <= 1'b0;
            r_def_type  <= '0;
            r_var_count <= '0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mtrr_pkg::CFG_MTRR_ENABLE:  r_mtrr_en   <= i_cfg_wdata[0];
                    mtrr_pkg::CFG_FIXED_ON:     r_fixed_on  <= i_cfg_wdata[0];
                    mtrr_pkg::CFG_DEFAULT_TYPE: r_def_type  <= i_cfg_wdata;
                    mtrr_pkg::CFG_VAR_COUNT:    r_var_count <= i_cfg_wdata[3:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_end      <= n_end;
        r_res      <= n_res;
        r_uni      <= n_uni;
        r_first    <= n_first;
        r_vi       <= n_vi;
        r_matched  <= n_matched;
        r_acc      <= n_acc;
        r_t        <= n_t;
        r_out_type <= n_out_type;
        r_out_uni  <= n_out_uni;
    end

    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.mem_type  = r_out_type;
    assign o_rsp.same_type = r_out_uni;

endmodule

>>> rtl/mtrr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package needed.
module mtrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 88
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/mtrr_fix_tab.sv
// Fixed-range type table: a RAM for the type bytes plus per-entry valid bits
// so that entries never written read as uncacheable. Uses mtrr_pkg, mtrr_ram.
module mtrr_fix_tab (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mtrr_pkg::t_fix_wr               i_wr,
    input  logic [mtrr_pkg::FIXED_AW-1:0]   i_raddr,
    output logic [mtrr_pkg::TYPE_W-1:0]     o_rdata
);

    logic [mtrr_pkg::FIXED_COUNT-1:0] r_vld;
    logic                             r_rd_vld;
    logic [mtrr_pkg::TYPE_W-1:0]      ram_rdata;

    mtrr_ram #(
        .WIDTH (mtrr_pkg::TYPE_W),
        .DEPTH (mtrr_pkg::FIXED_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr.en),
        .i_waddr (i_wr.idx[mtrr_pkg::FIXED_AW-1:0]),
        .i_wdata (i_wr.mtype),
        .i_raddr (i_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.idx[mtrr_pkg::FIXED_AW-1:0]] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rd_vld ? ram_rdata : mtrr_pkg::TYPE_UC;

endmodule

>>> rtl/mtrr_var_bank.sv
// Variable range registers and the shared base/mask compare unit that checks
// one selected range against an address per cycle. Uses mtrr_pkg.
module mtrr_var_bank #(
    parameter int VAR_RANGES     = mtrr_pkg::VAR_RANGES_DEF,
    parameter int PHYS_ADDR_BITS = mtrr_pkg::PHYS_ADDR_BITS_DEF,
    localparam int IW = (VAR_RANGES > 1) ? $clog2(VAR_RANGES) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mtrr_pkg::t_var_wr            i_wr,
    input  logic [IW-1:0]                i_sel,
    input  logic [PHYS_ADDR_BITS-1:0]    i_addr,
    output logic                         o_hit,
    output logic [mtrr_pkg::TYPE_W-1:0]  o_type
);

    localparam int SHW = mtrr_pkg::FRAME_W + mtrr_pkg::PAGE_SHIFT;

    logic [mtrr_pkg::FRAME_W-1:0] r_base [VAR_RANGES];
    logic [mtrr_pkg::FRAME_W-1:0] r_mask [VAR_RANGES];
    logic [mtrr_pkg::TYPE_W-1:0]  r_type [VAR_RANGES];
    logic [VAR_RANGES-1:0]        r_vld;

    logic                         wr_ok;
    logic [SHW-1:0]               base_sh;
    logic [SHW-1:0]               mask_sh;
    logic [PHYS_ADDR_BITS-1:0]    base_pa;
    logic [PHYS_ADDR_BITS-1:0]    mask_pa;

    assign wr_ok = i_wr.en && (32'(i_wr.idx) < 32'(VAR_RANGES));

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_base[i_wr.idx[IW-1:0]] <= i_wr.base;
            r_mask[i_wr.idx[IW-1:0]] <= i_wr.mask;
            r_type[i_wr.idx[IW-1:0]] <= i_wr.mtype;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_ok) begin
            r_vld[i_wr.idx[IW-1:0]] <= i_wr.vld;
        end
    end

    // Frames become byte addresses limited to the physical address space.
    assign base_sh = {r_base[i_sel], {mtrr_pkg::PAGE_SHIFT{1'b0}}};
    assign mask_sh = {r_mask[i_sel], {mtrr_pkg::PAGE_SHIFT{1'b0}}};
    assign base_pa = base_sh[PHYS_ADDR_BITS-1:0];
    assign mask_pa = mask_sh[PHYS_ADDR_BITS-1:0];

    assign o_hit  = r_vld[i_sel] && (((i_addr ^ base_pa) & mask_pa) == '0);
    assign o_type = r_type[i_sel];

endmodule
